/* hw/rtl/chsa_pkg.sv */
// Shared types and constants for the convex-hull support search block.
package chsa_pkg;

  localparam int COORD_W = 32;               // Q16.16 coordinate
  localparam int VTX_W   = 3 * COORD_W;      // one stored vertex {z, y, x}
  localparam int PROD_W  = 2 * COORD_W;      // exact coordinate product
  localparam int PAIR_W  = PROD_W + 1;       // x*dx + y*dy
  localparam int DOT_W   = PROD_W + 2;       // full exact dot product
  localparam int SLOT_W  = 8;
  localparam int CNT_W   = 9;                // vertex_count register
  localparam int IDX_W   = 8;                // best_index field

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } chsa_state_e;

  // controller -> datapath
  typedef struct packed {
    logic load_en;   // write the accepted vertex into its slot
    logic start;     // latch direction, clear running best
    logic rd_en;     // read one vertex for the scan
    logic push;      // result is handed to the output register
  } chsa_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic busy;      // reads still in flight through the dot pipeline
  } chsa_status_t;

endpackage

/* hw/rtl/convex_hull_support_argmax_top.sv */
// Top level of the convex-hull support search: ports, config register, output register.
// Load item: written to the vertex RAM at the edge that accepts it.
// Query item: scans n = min(vertex_count, MAX_VERTICES) vertices; the scan reads
//   one vertex per cycle from the single RAM read port, then a 4-stage dot pipeline
//   drains. One item in flight; an empty hull skips the scan and answers with found clear.
// Reset: vertex_count clears to 0, control and output valid clear; vertex RAM is not cleared.
module convex_hull_support_argmax_top #(
  parameter int MAX_VERTICES = 256
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  // input items
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [103:0]  s_axis_tdata,   // vertex_slot[7:0], coord_x[39:8], coord_y[71:40],
                                        // coord_z[103:72]
  input  logic [0:0]    s_axis_tuser,   // req_type
  // result items
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [7:0]    m_axis_tdata,   // best_index
  output logic [0:0]    m_axis_tuser,   // found
  // vertex_count register write
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [8:0]    cfg_data_i
);
  import chsa_pkg::*;

  localparam int AW = $clog2(MAX_VERTICES);

  chsa_cmd_t     cmd;
  chsa_status_t  status;
  logic [AW-1:0] rd_addr;
  logic [IDX_W-1:0] dp_best;
  logic          dp_found;
  logic          out_free;

  // config register, always ready
  logic [CNT_W-1:0] vertex_count_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vertex_count_q <= '0;
    end else if (cfg_valid_i) begin
      vertex_count_q <= cfg_data_i;
    end
  end

  // output register: a finished result waits here while the next item comes in
  logic             out_valid_q;
  logic [IDX_W-1:0] out_index_q;
  logic             out_found_q;

  assign out_free = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.push) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.push) begin
      out_index_q <= dp_best;
      out_found_q <= dp_found;
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_index_q;
  assign m_axis_tuser[0] = out_found_q;

  chsa_ctrl #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_req_type_i  (s_axis_tuser[0]),
    .in_ready_o     (s_axis_tready),
    .out_free_i     (out_free),
    .vertex_count_i (vertex_count_q),
    .status_i       (status),
    .cmd_o          (cmd),
    .rd_addr_o      (rd_addr)
  );

  chsa_dp #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .rd_addr_i    (rd_addr),
    .slot_i       (s_axis_tdata[SLOT_W-1:0]),
    .coords_i     (s_axis_tdata[SLOT_W +: VTX_W]),
    .status_o     (status),
    .best_index_o (dp_best),
    .found_o      (dp_found)
  );

  // a result is only handed off once the dot pipeline has drained
  a_push_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.push |-> !status.busy)
    else $error("result pushed while dot pipeline busy");

  // no new item is taken while a scan is still in flight
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |-> (!status.busy && !cmd.rd_en))
    else $error("item accepted during a scan");

  // output valid only rises from a controller push
  a_valid_from_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(cmd.push))
    else $error("output valid without a push");

endmodule

/* hw/rtl/chsa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module chsa_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* hw/rtl/chsa_dp.sv */
// Datapath: vertex store, exact dot-product pipeline and running argmax.
module chsa_dp #(
  parameter int MAX_VERTICES = 256
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  chsa_pkg::chsa_cmd_t                     cmd_i,
  input  logic [$clog2(MAX_VERTICES)-1:0]         rd_addr_i,
  input  logic [chsa_pkg::SLOT_W-1:0]             slot_i,
  input  logic [chsa_pkg::VTX_W-1:0]              coords_i,
  output chsa_pkg::chsa_status_t                  status_o,
  output logic [chsa_pkg::IDX_W-1:0]              best_index_o,
  output logic                                    found_o
);
  import chsa_pkg::*;

  localparam int AW = $clog2(MAX_VERTICES);

  logic              slot_ok;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [VTX_W-1:0]  rdata;

  assign slot_ok = 32'(slot_i) < 32'(MAX_VERTICES);
  assign we      = cmd_i.load_en && slot_ok;
  assign waddr   = AW'(slot_i);

  chsa_ram #(
    .WIDTH (VTX_W),
    .DEPTH (MAX_VERTICES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (coords_i),
    .re_i    (cmd_i.rd_en),
    .raddr_i (rd_addr_i),
    .rdata_o (rdata)
  );

  // direction, held for the whole scan
  logic signed [COORD_W-1:0] dir_x_q, dir_y_q, dir_z_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      dir_x_q <= coords_i[COORD_W-1:0];
      dir_y_q <= coords_i[2*COORD_W-1:COORD_W];
      dir_z_q <= coords_i[3*COORD_W-1:2*COORD_W];
    end
  end

  // valid pipeline: v1 = read data out of RAM, v2 = products,
  // v3 = partial sum, v4 = full dot
  logic v1_q, v2_q, v3_q, v4_q;
  logic [AW-1:0] idx1_q, idx2_q, idx3_q, idx4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.rd_en;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    idx1_q <= rd_addr_i;
    idx2_q <= idx1_q;
    idx3_q <= idx2_q;
    idx4_q <= idx3_q;
  end

  assign status_o.busy = v1_q || v2_q || v3_q || v4_q;

  // stage 2: three 32x32 products side by side
  logic signed [COORD_W-1:0] vx, vy, vz;
  logic signed [PROD_W-1:0]  px_q, py_q, pz_q;

  assign vx = rdata[COORD_W-1:0];
  assign vy = rdata[2*COORD_W-1:COORD_W];
  assign vz = rdata[3*COORD_W-1:2*COORD_W];

  always_ff @(posedge clk_i) begin
    px_q <= dir_x_q * vx;
    py_q <= dir_y_q * vy;
    pz_q <= dir_z_q * vz;
  end

  // stage 3: x + y, z carried along
  logic signed [PAIR_W-1:0] pair_q;
  logic signed [PROD_W-1:0] pz2_q;

  always_ff @(posedge clk_i) begin
    pair_q <= PAIR_W'(px_q) + PAIR_W'(py_q);
    pz2_q  <= pz_q;
  end

  // stage 4: full dot, exact in DOT_W bits
  logic signed [DOT_W-1:0] dot_q;

  always_ff @(posedge clk_i) begin
    dot_q <= DOT_W'(pair_q) + DOT_W'(pz2_q);
  end

  // running argmax; strict greater keeps the first maximum
  logic                    have_q;
  logic signed [DOT_W-1:0] best_dot_q;
  logic [AW-1:0]           best_idx_q;
  logic                    take;

  assign take = v4_q && (!have_q || (dot_q > best_dot_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
    end else if (cmd_i.start) begin
      have_q <= 1'b0;
    end else if (take) begin
      have_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      best_dot_q <= dot_q;
      best_idx_q <= idx4_q;
    end
  end

  assign found_o      = have_q;
  assign best_index_o = have_q ? IDX_W'(best_idx_q) : '0;

endmodule

/* hw/rtl/chsa_ctrl.sv */
// Controller: item intake, scan address sequencing and result hand-off.
module chsa_ctrl #(
  parameter int MAX_VERTICES = 256
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_req_type_i,
  output logic                              in_ready_o,
  input  logic                              out_free_i,
  input  logic [chsa_pkg::CNT_W-1:0]        vertex_count_i,
  input  chsa_pkg::chsa_status_t            status_i,
  output chsa_pkg::chsa_cmd_t               cmd_o,
  output logic [$clog2(MAX_VERTICES)-1:0]   rd_addr_o
);
  import chsa_pkg::*;

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int NW = (CW > CNT_W) ? CW : CNT_W;

  chsa_state_e state_q, state_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] idx_nx;
  logic [NW-1:0] cnt_ext, cnt_lim, cnt_sat;
  logic [CW-1:0] n_scan;

  // counts above the store size scan the whole store
  assign cnt_ext = NW'(vertex_count_i);
  assign cnt_lim = NW'(MAX_VERTICES);
  assign cnt_sat = (cnt_ext > cnt_lim) ? cnt_lim : cnt_ext;
  assign n_scan  = CW'(cnt_sat);
  assign idx_nx  = idx_q + 1'b1;

  assign rd_addr_o = idx_q[AW-1:0];

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_req_type_i == REQ_QUERY) begin
            cmd_o.start = 1'b1;
            idx_d       = '0;
            state_d     = (n_scan == '0) ? ST_DRAIN : ST_SCAN;
          end else begin
            cmd_o.load_en = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.rd_en = 1'b1;
        idx_d       = idx_nx;
        if (idx_nx == n_scan) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status_i.busy) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free_i) begin
          cmd_o.push = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

endmodule
